/* rtl/ksmd_pkg.sv */
// shared types and constants of the knob scan smoothing block
`default_nettype none

package ksmd_pkg;

   localparam int KNOB_COUNT = 42;
   localparam int KNOB_W     = 6;
   localparam int SAMPLE_W   = 10;
   localparam int HOST_W     = 8;
   localparam int MIDI_W     = 7;
   localparam int ALPHA_W    = 9;
   localparam int THRESH_W   = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_Q8   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 2'd1;

   localparam logic OP_SCAN   = 1'b0;
   localparam logic OP_INJECT = 1'b1;

   localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = 9'd77;
   localparam logic [ALPHA_W-1:0]  ALPHA_MAX    = 9'd256;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd2;
   localparam logic [MIDI_W-1:0]   MIDI_MAX     = 7'd127;

   typedef struct packed {
      logic                opcode;
      logic [KNOB_W-1:0]   target_knob;
      logic [SAMPLE_W-1:0] sample_a;
      logic [SAMPLE_W-1:0] sample_b;
      logic [SAMPLE_W-1:0] sample_c;
      logic [SAMPLE_W-1:0] sample_d;
      logic [HOST_W-1:0]   host_level;
   } req_type;

   typedef struct packed {
      logic [KNOB_W-1:0]   knob_index;
      logic [MIDI_W-1:0]   level_7bit;
      logic [SAMPLE_W-1:0] level_raw;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/ksmd_ram.sv */
// generic single-port-write ram with registered read
`default_nettype none

module ksmd_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 42
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* rtl/knob_scan_smooth_deadband_top.sv */
// top level of the knob scan smoothing and deadband change detector
//
// req channel (valid/ready) carries one request: a scan of the next knob in
// round-robin order with four raw samples, or an inject of a host midi value
// into a chosen knob. rsp channel (valid/ready) carries at most one result per
// request: knob index, 7-bit level and 10-bit raw level.
// a request passes through the compute stage register and then the result register.
// throughput: one request per cycle unless rsp_ready stalls the pipe; the per-knob
// stores are rams with a registered read, so a request reads at acceptance and is
// computed and written back in the compute stage, with forwarding of the previous write.
// an inject to a knob beyond the knob count is taken and dropped.
// csr port: writes to alpha_q8 (index 0) and the deadband threshold (index 1)
// take effect at once; other indexes are ignored.
// reset: scan position goes to knob 0, every smoothed value reads as zero and
// every reported value as minus one (per-entry valid bits), csrs to defaults.
// stall: when rsp_ready is low the result register holds, the compute stage
// holds behind it and req_ready drops once the compute stage is also full;
// no result is lost or repeated.
`default_nettype none

module knob_scan_smooth_deadband_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire ksmd_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output ksmd_pkg::rsp_type                   rsp_data,
   input  wire logic                           csr_we,
   input  wire logic [ksmd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [ksmd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import ksmd_pkg::*;

   localparam logic [KNOB_W-1:0] KNOB_LAST  = KNOB_W'(KNOB_COUNT - 1);
   localparam logic [KNOB_W:0]   KNOB_LIMIT = (KNOB_W + 1)'(KNOB_COUNT);

   // csrs
   logic [ALPHA_W-1:0]  alpha_ff;
   logic [THRESH_W-1:0] thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff  <= ALPHA_RESET;
         thresh_ff <= THRESH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ALPHA_Q8:  alpha_ff  <= csr_wdata[ALPHA_W-1:0];
            CSR_THRESHOLD: thresh_ff <= csr_wdata[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake
   logic accept;
   logic s1_valid_ff;
   logic s1_go;
   logic out_free;
   logic rsp_valid_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_go     = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign accept    = req_valid && req_ready;

   // accept stage
   logic [KNOB_W-1:0]   pos_ff;
   logic [KNOB_W-1:0]   pos_eff;
   logic [KNOB_W-1:0]   rd_addr;
   logic                drop;
   logic [SAMPLE_W+1:0] sum;
   logic [MIDI_W-1:0]   level_clamp;

   assign pos_eff = ({1'b0, pos_ff} >= KNOB_LIMIT) ? '0 : pos_ff;
   assign rd_addr = (req_data.opcode == OP_INJECT) ? req_data.target_knob : pos_eff;
   assign drop    = (req_data.opcode == OP_INJECT) &&
                    ({1'b0, req_data.target_knob} >= KNOB_LIMIT);
   assign sum     = (SAMPLE_W + 2)'(req_data.sample_a) + (SAMPLE_W + 2)'(req_data.sample_b) +
                    (SAMPLE_W + 2)'(req_data.sample_c) + (SAMPLE_W + 2)'(req_data.sample_d);
   assign level_clamp = (req_data.host_level > HOST_W'(MIDI_MAX)) ?
                        MIDI_MAX : req_data.host_level[MIDI_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (accept && req_data.opcode == OP_SCAN) begin
         pos_ff <= (pos_eff == KNOB_LAST) ? '0 : pos_eff + 1'b1;
      end
   end

   // compute stage registers
   logic                s1_op_ff;
   logic [KNOB_W-1:0]   s1_addr_ff;
   logic [SAMPLE_W-1:0] s1_avg_ff;
   logic [MIDI_W-1:0]   s1_level_ff;
   logic                sm_hit_ff;
   logic                rep_hit_ff;
   logic [SAMPLE_W-1:0] sm_fwd_ff;
   logic [SAMPLE_W-1:0] rep_fwd_ff;

   logic                sm_we;
   logic                rep_we;
   logic [SAMPLE_W-1:0] sm_wdata;
   logic [SAMPLE_W-1:0] rep_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= accept && !drop;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= req_data.opcode;
         s1_addr_ff  <= rd_addr;
         s1_avg_ff   <= sum[SAMPLE_W+1:2];
         s1_level_ff <= level_clamp;
         sm_hit_ff   <= sm_we && (s1_addr_ff == rd_addr);
         rep_hit_ff  <= rep_we && (s1_addr_ff == rd_addr);
         sm_fwd_ff   <= sm_wdata;
         rep_fwd_ff  <= rep_wdata;
      end
   end

   // per-knob stores
   logic [SAMPLE_W-1:0]   sm_rdata;
   logic [SAMPLE_W-1:0]   rep_rdata;
   logic [KNOB_COUNT-1:0] sm_vld_ff;
   logic [KNOB_COUNT-1:0] rep_vld_ff;

   ksmd_ram #(.WIDTH(SAMPLE_W), .DEPTH(KNOB_COUNT)) u_sm_ram (
      .clock (clock),
      .we    (sm_we),
      .waddr (s1_addr_ff),
      .wdata (sm_wdata),
      .re    (accept),
      .raddr (rd_addr),
      .rdata (sm_rdata)
   );

   ksmd_ram #(.WIDTH(SAMPLE_W), .DEPTH(KNOB_COUNT)) u_rep_ram (
      .clock (clock),
      .we    (rep_we),
      .waddr (s1_addr_ff),
      .wdata (rep_wdata),
      .re    (accept),
      .raddr (rd_addr),
      .rdata (rep_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sm_vld_ff  <= '0;
         rep_vld_ff <= '0;
      end else begin
         if (sm_we) begin
            sm_vld_ff[s1_addr_ff] <= 1'b1;
         end
         if (rep_we) begin
            rep_vld_ff[s1_addr_ff] <= 1'b1;
         end
      end
   end

   // smoothing
   logic [SAMPLE_W-1:0]        old_sm;
   logic [ALPHA_W-1:0]         alpha_sat;
   logic signed [SAMPLE_W:0]   delta;
   logic signed [ALPHA_W:0]    alpha_s;
   logic signed [SAMPLE_W+ALPHA_W+1:0] prod;
   logic signed [SAMPLE_W+2:0] step;
   logic signed [SAMPLE_W+2:0] sm_full;
   logic [SAMPLE_W-1:0]        sm_new;

   assign old_sm    = sm_hit_ff ? sm_fwd_ff :
                      (sm_vld_ff[s1_addr_ff] ? sm_rdata : '0);
   assign alpha_sat = (alpha_ff > ALPHA_MAX) ? ALPHA_MAX : alpha_ff;
   assign delta     = signed'({1'b0, s1_avg_ff}) - signed'({1'b0, old_sm});
   assign alpha_s   = signed'({1'b0, alpha_sat});
   assign prod      = delta * alpha_s;
   assign step      = prod[SAMPLE_W+ALPHA_W+1:8];
   assign sm_full   = signed'({3'b000, old_sm}) + step;
   assign sm_new    = sm_full[SAMPLE_W-1:0];

   // deadband
   logic signed [SAMPLE_W:0]   rep_old;
   logic signed [SAMPLE_W+1:0] diff;
   logic [SAMPLE_W+1:0]        diff_abs;
   logic                       changed;

   assign rep_old  = rep_hit_ff ? signed'({1'b0, rep_fwd_ff}) :
                     (rep_vld_ff[s1_addr_ff] ? signed'({1'b0, rep_rdata}) : '1);
   assign diff     = signed'({2'b00, sm_new}) - signed'({rep_old[SAMPLE_W], rep_old});
   assign diff_abs = diff[SAMPLE_W+1] ? unsigned'(-diff) : unsigned'(diff);
   assign changed  = diff_abs > (SAMPLE_W + 2)'(thresh_ff);

   // v*127/1023 with a one-step correction
   logic [SAMPLE_W+6:0] midi_prod;
   logic [MIDI_W-1:0]   midi_est;
   logic [MIDI_W:0]     midi_up;
   logic [SAMPLE_W+7:0] midi_back;
   logic [MIDI_W-1:0]   midi_level;

   assign midi_prod  = {sm_new, 7'b0} - (SAMPLE_W + 7)'(sm_new);
   assign midi_est   = midi_prod[SAMPLE_W+6:10];
   assign midi_up    = (MIDI_W + 1)'(midi_est) + 1'b1;
   assign midi_back  = {midi_up, 10'b0} - (SAMPLE_W + 8)'(midi_up);
   assign midi_level = (midi_back <= {1'b0, midi_prod}) ? midi_est + 1'b1 : midi_est;

   // v*1023/127 as v*8 + floor(v*7/127)
   logic [SAMPLE_W-1:0] inj_seven;
   logic [2:0]          inj_frac;
   logic [SAMPLE_W-1:0] inj_raw;

   assign inj_seven = {s1_level_ff, 3'b000} - SAMPLE_W'(s1_level_ff);

   always_comb begin
      inj_frac = '0;
      for (int k = 1; k < 8; k++) begin
         if (inj_seven >= SAMPLE_W'(k * 127)) begin
            inj_frac = 3'(k);
         end
      end
   end

   assign inj_raw = {s1_level_ff, 3'b000} + SAMPLE_W'(inj_frac);

   // write back and result
   logic    emit;
   rsp_type rsp_in;
   rsp_type rsp_ff;

   always_comb begin
      if (s1_op_ff == OP_INJECT) begin
         emit      = 1'b1;
         sm_we     = s1_go;
         rep_we    = s1_go;
         sm_wdata  = inj_raw;
         rep_wdata = inj_raw;
         rsp_in.knob_index = s1_addr_ff;
         rsp_in.level_7bit = s1_level_ff;
         rsp_in.level_raw  = inj_raw;
      end else begin
         emit      = changed;
         sm_we     = s1_go;
         rep_we    = s1_go && changed;
         sm_wdata  = sm_new;
         rep_wdata = sm_new;
         rsp_in.knob_index = s1_addr_ff;
         rsp_in.level_7bit = midi_level;
         rsp_in.level_raw  = sm_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

/* tb/knob_scan_smooth_deadband_tb.sv */
// self-checking testbench for the knob scan smoothing and deadband change detector
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ksmd_pkg::*;

   localparam int RAW_MAX      = 1023;
   localparam int LEVEL_TOP    = int'(MIDI_MAX);
   localparam int DRAIN_CYCLES = 6;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PRINT_LIMIT  = 100;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predicted block state
   int alpha_weight;
   int deadband;
   int next_knob;
   int smooth_level [KNOB_COUNT];
   int last_reported [KNOB_COUNT];
   int knob_target [KNOB_COUNT];
   rsp_type expected_changes [$];

   int error_count        = 0;
   int cycle_count        = 0;
   bit idle_enable        = 1'b1;
   int sender_idle_pct    = 20;
   int receiver_stall_pct = 20;

   knob_scan_smooth_deadband_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   task automatic report_mismatch(string what, int got, int want);
      if (error_count < PRINT_LIMIT) begin
         $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
                  want);
      end
      error_count++;
   endtask

   function automatic void predict_request(req_type r);
      rsp_type change;
      int knob, level, raw, avg, old, weight, smoothed, distance;
      if (r.opcode == OP_INJECT) begin
         knob = int'(r.target_knob);
         if (knob >= KNOB_COUNT) return;
         level = (r.host_level > MIDI_MAX) ? LEVEL_TOP : int'(r.host_level);
         raw = level * RAW_MAX / LEVEL_TOP;
         smooth_level[knob] = raw;
         last_reported[knob] = raw;
         change.knob_index = KNOB_W'(knob);
         change.level_7bit = MIDI_W'(level);
         change.level_raw = SAMPLE_W'(raw);
         expected_changes.push_back(change);
      end else begin
         knob = (next_knob >= KNOB_COUNT) ? 0 : next_knob;
         avg = (int'(r.sample_a) + int'(r.sample_b) + int'(r.sample_c) + int'(r.sample_d)) >>> 2;
         weight = (alpha_weight > int'(ALPHA_MAX)) ? int'(ALPHA_MAX) : alpha_weight;
         old = smooth_level[knob];
         smoothed = old + (((avg - old) * weight) >>> 8);
         smooth_level[knob] = smoothed;
         distance = smoothed - last_reported[knob];
         if (distance < 0) distance = -distance;
         if (distance > deadband) begin
            last_reported[knob] = smoothed;
            change.knob_index = KNOB_W'(knob);
            change.level_7bit = MIDI_W'(smoothed * LEVEL_TOP / RAW_MAX);
            change.level_raw = SAMPLE_W'(smoothed);
            expected_changes.push_back(change);
         end
         next_knob = (knob + 1 >= KNOB_COUNT) ? 0 : knob + 1;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_changes.size() == 0) begin
            report_mismatch("unrequested result for knob", int'(rsp_data.knob_index), -1);
         end else begin
            want = expected_changes.pop_front();
            if (rsp_data.knob_index !== want.knob_index)
               report_mismatch("knob_index", int'(rsp_data.knob_index),
                               int'(want.knob_index));
            if (rsp_data.level_7bit !== want.level_7bit)
               report_mismatch("level_7bit", int'(rsp_data.level_7bit),
                               int'(want.level_7bit));
            if (rsp_data.level_raw !== want.level_raw)
               report_mismatch("level_raw", int'(rsp_data.level_raw), int'(want.level_raw));
         end
      end
   end

   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left == 0 && idle_enable && $urandom_range(0, 99) < receiver_stall_pct)
            stall_left = $urandom_range(1, 15);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_request(req_type r);
      if (idle_enable && $urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      predict_request(r);
   endtask

   // hold off until every predicted change has come back and the pipe is empty
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_changes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      if (index == CSR_ALPHA_Q8) alpha_weight = int'(value[ALPHA_W-1:0]);
      else if (index == CSR_THRESHOLD) deadband = int'(value[THRESH_W-1:0]);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type random_request();
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      return noise[$bits(req_type)-1:0];
   endfunction

   function automatic req_type scan_request(int a, int b, int c, int d);
      req_type r;
      r = random_request();
      r.opcode = OP_SCAN;
      r.sample_a = SAMPLE_W'(a);
      r.sample_b = SAMPLE_W'(b);
      r.sample_c = SAMPLE_W'(c);
      r.sample_d = SAMPLE_W'(d);
      return r;
   endfunction

   function automatic req_type inject_request(int knob, int level);
      req_type r;
      r = random_request();
      r.opcode = OP_INJECT;
      r.target_knob = KNOB_W'(knob);
      r.host_level = HOST_W'(level);
      return r;
   endfunction

   function automatic int sample_near(int center);
      int v;
      v = center + int'($urandom_range(0, 12)) - 6;
      if (v < 0) v = 0;
      if (v > RAW_MAX) v = RAW_MAX;
      return v;
   endfunction

   task automatic run_traffic(int count);
      req_type r;
      int i, kind, center;
      for (i = 0; i < count; i++) begin
         kind = $urandom_range(0, 99);
         if (kind < 12) begin
            r = random_request();
            r.opcode = OP_INJECT;
            if ($urandom_range(0, 1))
               r.target_knob = KNOB_W'($urandom_range(0, KNOB_COUNT - 1));
         end else if (kind < 20) begin
            r = random_request();
            r.opcode = OP_SCAN;
         end else begin
            if ($urandom_range(0, 15) == 0)
               knob_target[next_knob] = int'($urandom_range(0, RAW_MAX));
            center = knob_target[next_knob];
            r = scan_request(sample_near(center), sample_near(center), sample_near(center),
                             sample_near(center));
         end
         send_request(r);
      end
   endtask

   task automatic test_default_config();
      send_request(scan_request(0, 0, 0, 0));
      send_request(scan_request(RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX));
      send_request(scan_request(1, 1, 1, 0));
      send_request(scan_request(1023, 1022, 1021, 1020));
   endtask

   task automatic test_inject();
      send_request(inject_request(0, 0));
      send_request(inject_request(KNOB_COUNT - 1, 127));
      send_request(inject_request(5, 200));
      send_request(inject_request(63, 255));
      send_request(inject_request(KNOB_COUNT, 128));
   endtask

   task automatic test_register_extremes();
      settle();
      write_register(CSR_ALPHA_Q8, CSR_DATA_W'(ALPHA_MAX));
      write_register(CSR_THRESHOLD, CSR_DATA_W'(0));
      send_request(scan_request(RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX));
      send_request(scan_request(512, 513, 514, 515));
      send_request(scan_request(3, 0, 0, 0));
      settle();
      write_register(CSR_ALPHA_Q8, 10'h3FF);
      write_register(CSR_THRESHOLD, 10'h3FF);
      send_request(scan_request(RAW_MAX, 0, RAW_MAX, 0));
      send_request(scan_request(700, 701, 702, 703));
      settle();
      write_register(CSR_ALPHA_Q8, CSR_DATA_W'(0));
      write_register(CSR_THRESHOLD, CSR_DATA_W'(0));
      send_request(scan_request(RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX));
      send_request(scan_request(0, 0, 0, 0));
      settle();
      write_register(CSR_ALPHA_Q8, CSR_DATA_W'(128));
      write_register(CSR_THRESHOLD, CSR_DATA_W'(5));
      write_register(CSR_SPARE_LO, 10'h3FF);
      write_register(CSR_SPARE_HI, CSR_DATA_W'(0));
      send_request(scan_request(900, 901, 902, 903));
      send_request(scan_request(40, 41, 42, 43));
   endtask

   task automatic test_random_traffic();
      int phase;
      for (phase = 0; phase < 4; phase++) begin
         settle();
         case (phase)
            0: begin
               write_register(CSR_ALPHA_Q8, CSR_DATA_W'($urandom_range(0, 256)));
               write_register(CSR_THRESHOLD, CSR_DATA_W'($urandom_range(0, 8)));
            end
            1: begin
               write_register(CSR_ALPHA_Q8, CSR_DATA_W'($urandom_range(0, RAW_MAX)));
               write_register(CSR_THRESHOLD, CSR_DATA_W'($urandom_range(0, RAW_MAX)));
            end
            2: begin
               write_register(CSR_ALPHA_Q8, CSR_DATA_W'(ALPHA_RESET));
               write_register(CSR_THRESHOLD, CSR_DATA_W'(0));
            end
            default: begin
               write_register(CSR_ALPHA_Q8, CSR_DATA_W'($urandom_range(1, 64)));
               write_register(CSR_THRESHOLD, CSR_DATA_W'($urandom_range(0, 3)));
            end
         endcase
         sender_idle_pct = $urandom_range(0, 40);
         receiver_stall_pct = $urandom_range(0, 40);
         run_traffic(220);
      end
   endtask

   task automatic test_back_to_back();
      settle();
      idle_enable = 1'b0;
      write_register(CSR_ALPHA_Q8, CSR_DATA_W'($urandom_range(64, 256)));
      write_register(CSR_THRESHOLD, CSR_DATA_W'($urandom_range(0, 4)));
      run_traffic(120);
   endtask

   initial begin
      alpha_weight = int'(ALPHA_RESET);
      deadband = int'(THRESH_RESET);
      next_knob = 0;
      foreach (smooth_level[k]) begin
         smooth_level[k] = 0;
         last_reported[k] = -1;
         knob_target[k] = int'($urandom_range(0, RAW_MAX));
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_config();
      test_inject();
      test_register_extremes();
      test_random_traffic();
      test_back_to_back();
      settle();
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* knob_scan_smooth_deadband_top.f */
rtl/ksmd_pkg.sv
rtl/ksmd_ram.sv
rtl/knob_scan_smooth_deadband_top.sv
tb/knob_scan_smooth_deadband_tb.sv
